/* rtl/plrc_pkg.sv */
// plrc_pkg: shared types and codes of the piecewise linear rgb colormap
// request classes, engine states, status codes and the queued request record
// no dependencies
`default_nettype none

package plrc_pkg;

  localparam int unsigned PosW = 17;
  localparam int unsigned ValW = 17;
  localparam int unsigned IdxW = 4;
  localparam int unsigned NumChannels = 3;

  localparam logic [1:0] ReqEval   = 2'd0;
  localparam logic [1:0] ReqInsert = 2'd1;
  localparam logic [1:0] ReqRemove = 2'd2;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusBadIdx = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_EVAL,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       channel;
    logic [PosW-1:0]  position;
    logic [ValW-1:0]  key_value;
    logic [IdxW-1:0]  key_index;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_START,
    ST_EV_CHK,
    ST_EV_MA,
    ST_EV_MB,
    ST_EV_SCALE,
    ST_EV_SAT,
    ST_EV_DIV,
    ST_EV_NEXT,
    ST_INS_START,
    ST_INS_RD,
    ST_INS_CHK,
    ST_RM_START,
    ST_RM_RD,
    ST_RM_CHK,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/piecewise_linear_rgb_colormap.sv */
// evaluate time grows with the keys per table, through the one-key-per-cycle scan and
// the 8-step byte divider; insert and remove time grow with the keys moved, through
// the single read and write port of the key ram
// throughput: one request in the engine at a time, the front queue holds two more
// reset: key tables empty, queue and result register empty; key ram not cleared
`default_nettype none

module piecewise_linear_rgb_colormap #(
  parameter int unsigned KEYS_PER_CHANNEL = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [16:0] position, [33:17] key_value, [37:34] key_index, [39:38] zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] req_type, [3:2] channel
  input  wire logic [3:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [25:24] status, [31:26] zero
  output logic [31:0]      m_axis_tdata
);
  import plrc_pkg::*;

  req_t       req;
  logic       req_valid, req_ready;
  logic [7:0] red, green, blue;
  logic [1:0] status;

  // front end: decode the request kind and buffer up to two beats
  plrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser[1:0]),
    .channel_i   (s_axis_tuser[3:2]),
    .position_i  (s_axis_tdata[16:0]),
    .key_value_i (s_axis_tdata[33:17]),
    .key_index_i (s_axis_tdata[37:34]),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready)
  );

  // back end: key tables, search, interpolation and result register
  plrc_engine #(
    .KEYS_PER_CHANNEL (KEYS_PER_CHANNEL)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue),
    .status_o    (status),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, status, blue, green, red};

endmodule

`default_nettype wire

/* rtl/plrc_ram.sv */
// plrc_ram: generic single write port, single read port ram
// registered read data, no reset on the array; no dependencies
`default_nettype none

module plrc_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/plrc_front.sv */
// plrc_front: classifies request beats and holds them in a two entry queue
// depends on plrc_pkg
`default_nettype none

module plrc_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [1:0]                 channel_i,
  input  wire logic [plrc_pkg::PosW-1:0]  position_i,
  input  wire logic [plrc_pkg::ValW-1:0]  key_value_i,
  input  wire logic [plrc_pkg::IdxW-1:0]  key_index_i,
  output plrc_pkg::req_t                  req_o,
  output logic                            req_valid_o,
  input  wire logic                       req_ready_i
);
  import plrc_pkg::*;

  req_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  req_t       cls;
  logic       push, pop;

  // channel three makes table requests do nothing
  always_comb begin
    cls.channel   = channel_i;
    cls.position  = position_i;
    cls.key_value = key_value_i;
    cls.key_index = key_index_i;
    case (req_type_i)
      ReqEval:   cls.op = OP_EVAL;
      ReqInsert: cls.op = (channel_i == 2'd3) ? OP_NOP : OP_INSERT;
      ReqRemove: cls.op = (channel_i == 2'd3) ? OP_NOP : OP_REMOVE;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign req_valid_o = (fill_q != 2'd0);
  assign req_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/plrc_engine.sv */
// plrc_engine: sequencer that evaluates, inserts and removes keys
// key store in plrc_ram, iterative byte divider, result register
// depends on plrc_pkg and plrc_ram
`default_nettype none

module plrc_engine #(
  parameter int unsigned KEYS_PER_CHANNEL = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire plrc_pkg::req_t req_i,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [1:0]          status_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i
);
  import plrc_pkg::*;

  localparam int unsigned NumEntries = NumChannels * KEYS_PER_CHANNEL;
  localparam int unsigned AW   = $clog2(NumEntries);
  localparam int unsigned CW   = $clog2(KEYS_PER_CHANNEL + 1);
  localparam int unsigned CMPW = (CW > IdxW) ? CW : IdxW;
  localparam int unsigned DW   = PosW + ValW;
  localparam int unsigned NW   = 2 * ValW;
  localparam int unsigned RW   = NW - 8;

  state_e            state_q, state_d;
  logic [1:0]        chan_q, chan_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CW-1:0]     cnt_q [NumChannels];
  logic [CW-1:0]     cnt_d [NumChannels];
  logic [CW-1:0]     j_q, j_d;
  logic [PosW-1:0]   prev_pos_q, prev_pos_d;
  logic [ValW-1:0]   prev_val_q, prev_val_d;
  logic [NW-1:0]     mul_q, mul_d;
  logic [NW-1:0]     num_q, num_d;
  logic [PosW-1:0]   den_q, den_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [7:0]        quo_q, quo_d;
  logic [2:0]        dbit_q, dbit_d;
  logic [7:0]        rgb_q [NumChannels];
  logic [7:0]        rgb_d [NumChannels];
  logic [1:0]        stat_q, stat_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        ored_q, ored_d, ogrn_q, ogrn_d, oblu_q, oblu_d;
  logic [1:0]        ostat_q, ostat_d;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr, base;
  logic [DW-1:0]     wr_data, rd_data;
  logic [PosW-1:0]   rd_pos;
  logic [ValW-1:0]   rd_val;
  logic [CW-1:0]     cur_cnt;
  logic [CW:0]       j_plus;
  logic              cnt_inc, cnt_dec, byte_we;
  logic [7:0]        byte_val;
  logic [NW+7:0]     scaled;
  logic [RW-1:0]     trial;
  logic [7:0]        quo_new;

  plrc_ram #(
    .WIDTH (DW),
    .DEPTH (NumEntries)
  ) u_keys (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_pos = rd_data[DW-1:ValW];
  assign rd_val = rd_data[ValW-1:0];
  assign base   = AW'(chan_q) * AW'(KEYS_PER_CHANNEL);
  assign j_plus = {1'b0, j_q} + (CW+1)'(1);
  assign scaled = ({num_q, 8'd0} - {8'd0, num_q}) >> 16;
  assign trial  = RW'(den_q) << dbit_q;

  always_comb begin
    case (chan_q)
      2'd0:    cur_cnt = cnt_q[0];
      2'd1:    cur_cnt = cnt_q[1];
      2'd2:    cur_cnt = cnt_q[2];
      default: cur_cnt = '0;
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = ovalid_q;
  assign red_o       = ored_q;
  assign green_o     = ogrn_q;
  assign blue_o      = oblu_q;
  assign status_o    = ostat_q;

  always_comb begin
    state_d    = state_q;
    chan_d     = chan_q;
    pos_d      = pos_q;
    val_d      = val_q;
    idx_d      = idx_q;
    j_d        = j_q;
    prev_pos_d = prev_pos_q;
    prev_val_d = prev_val_q;
    mul_d      = mul_q;
    num_d      = num_q;
    den_d      = den_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dbit_d     = dbit_q;
    stat_d     = stat_q;
    ored_d     = ored_q;
    ogrn_d     = ogrn_q;
    oblu_d     = oblu_q;
    ostat_d    = ostat_q;
    ovalid_d   = ovalid_q && !res_ready_i;
    wr_en      = 1'b0;
    wr_addr    = base + AW'(j_q);
    wr_data    = {pos_q, val_q};
    rd_en      = 1'b0;
    rd_addr    = base;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    byte_we    = 1'b0;
    byte_val   = 8'd0;
    quo_new    = quo_q;
    for (int c = 0; c < NumChannels; c++) begin
      rgb_d[c] = rgb_q[c];
    end

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          pos_d  = req_i.position;
          val_d  = req_i.key_value;
          idx_d  = req_i.key_index;
          stat_d = StatusOk;
          for (int c = 0; c < NumChannels; c++) begin
            rgb_d[c] = 8'd0;
          end
          chan_d = (req_i.op == OP_EVAL) ? 2'd0 : req_i.channel;
          case (req_i.op)
            OP_EVAL:   state_d = ST_EV_START;
            OP_INSERT: state_d = ST_INS_START;
            OP_REMOVE: state_d = ST_RM_START;
            default:   state_d = ST_DONE;
          endcase
        end
      end

      ST_EV_START: begin
        j_d = '0;
        if (cur_cnt == '0) begin
          byte_we = 1'b1;
          state_d = ST_EV_NEXT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = base;
          state_d = ST_EV_CHK;
        end
      end

      ST_EV_CHK: begin
        if (rd_pos >= pos_q) begin
          if (rd_pos == pos_q) begin
            num_d   = NW'(rd_val);
            den_d   = PosW'(1);
            state_d = ST_EV_SCALE;
          end else if (j_q == '0) begin
            byte_we = 1'b1;
            state_d = ST_EV_NEXT;
          end else begin
            state_d = ST_EV_MA;
          end
        end else begin
          prev_pos_d = rd_pos;
          prev_val_d = rd_val;
          if (j_plus == {1'b0, cur_cnt}) begin
            byte_we = 1'b1;
            state_d = ST_EV_NEXT;
          end else begin
            j_d     = j_plus[CW-1:0];
            rd_en   = 1'b1;
            rd_addr = base + AW'(j_plus);
          end
        end
      end

      ST_EV_MA: begin
        mul_d   = NW'(prev_val_q) * NW'(rd_pos - pos_q);
        state_d = ST_EV_MB;
      end

      ST_EV_MB: begin
        num_d   = mul_q + NW'(rd_val) * NW'(pos_q - prev_pos_q);
        den_d   = rd_pos - prev_pos_q;
        state_d = ST_EV_SCALE;
      end

      ST_EV_SCALE: begin
        rem_d   = scaled[RW-1:0];
        state_d = ST_EV_SAT;
      end

      ST_EV_SAT: begin
        if (rem_q >= (RW'(den_q) << 8)) begin
          byte_we  = 1'b1;
          byte_val = 8'hFF;
          state_d  = ST_EV_NEXT;
        end else begin
          quo_d   = 8'd0;
          dbit_d  = 3'd7;
          state_d = ST_EV_DIV;
        end
      end

      ST_EV_DIV: begin
        if (rem_q >= trial) begin
          rem_d           = rem_q - trial;
          quo_new[dbit_q] = 1'b1;
        end
        quo_d  = quo_new;
        dbit_d = dbit_q - 3'd1;
        if (dbit_q == 3'd0) begin
          byte_we  = 1'b1;
          byte_val = quo_new;
          state_d  = ST_EV_NEXT;
        end
      end

      ST_EV_NEXT: begin
        if (chan_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          chan_d  = chan_q + 2'd1;
          state_d = ST_EV_START;
        end
      end

      ST_INS_START: begin
        if (cur_cnt >= CW'(KEYS_PER_CHANNEL)) begin
          stat_d  = StatusFull;
          state_d = ST_DONE;
        end else begin
          j_d     = cur_cnt;
          state_d = ST_INS_RD;
        end
      end

      // walk down from the top, moving keys at or above the new position up
      ST_INS_RD: begin
        if (j_q == '0) begin
          wr_en   = 1'b1;
          cnt_inc = 1'b1;
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = base + AW'(j_q - CW'(1));
          state_d = ST_INS_CHK;
        end
      end

      ST_INS_CHK: begin
        wr_en = 1'b1;
        if (rd_pos >= pos_q) begin
          wr_data = rd_data;
          j_d     = j_q - CW'(1);
          state_d = ST_INS_RD;
        end else begin
          cnt_inc = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_RM_START: begin
        if (CMPW'(idx_q) >= CMPW'(cur_cnt)) begin
          stat_d  = StatusBadIdx;
          state_d = ST_DONE;
        end else begin
          j_d     = CW'(idx_q);
          state_d = ST_RM_RD;
        end
      end

      ST_RM_RD: begin
        if (j_plus >= {1'b0, cur_cnt}) begin
          cnt_dec = 1'b1;
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = base + AW'(j_plus);
          state_d = ST_RM_CHK;
        end
      end

      ST_RM_CHK: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        j_d     = j_plus[CW-1:0];
        state_d = ST_RM_RD;
      end

      ST_DONE: begin
        if (!ovalid_q || res_ready_i) begin
          ored_d   = rgb_q[0];
          ogrn_d   = rgb_q[1];
          oblu_d   = rgb_q[2];
          ostat_d  = stat_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    for (int c = 0; c < NumChannels; c++) begin
      cnt_d[c] = cnt_q[c];
      if (chan_q == 2'(c)) begin
        if (cnt_inc) cnt_d[c] = cnt_q[c] + CW'(1);
        if (cnt_dec) cnt_d[c] = cnt_q[c] - CW'(1);
        if (byte_we) rgb_d[c] = byte_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      for (int c = 0; c < NumChannels; c++) begin
        cnt_q[c] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      for (int c = 0; c < NumChannels; c++) begin
        cnt_q[c] <= cnt_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q     <= chan_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    j_q        <= j_d;
    prev_pos_q <= prev_pos_d;
    prev_val_q <= prev_val_d;
    mul_q      <= mul_d;
    num_q      <= num_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dbit_q     <= dbit_d;
    stat_q     <= stat_d;
    ored_q     <= ored_d;
    ogrn_q     <= ogrn_d;
    oblu_q     <= oblu_d;
    ostat_q    <= ostat_d;
    for (int c = 0; c < NumChannels; c++) begin
      rgb_q[c] <= rgb_d[c];
    end
  end

endmodule

`default_nettype wire
